FILE: hdl/dlrls_pkg.sv
// ----------------------------------------------------------------------------
// dlrls_pkg: shared types and constants for DP link rate / lane selection
// Field widths, code values, bandwidth thresholds and the bits-per-pixel
// lookup used by the link rate and lane count selector.
// ----------------------------------------------------------------------------
package dlrls_pkg;

  // Field widths
  localparam int PIX_W      = 22;
  localparam int FMT_W      = 3;
  localparam int DEPTH_W    = 3;
  localparam int BW_W       = 28;
  localparam int RATE_W     = 2;
  localparam int LANE_W     = 2;
  localparam int BPP_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int QUOT_W     = 21;

  // Color format codes; anything above FMT_RAW counts as RGB
  localparam logic [FMT_W-1:0] FMT_RGB    = 3'd0;
  localparam logic [FMT_W-1:0] FMT_YUV444 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_YUV422 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_YUV420 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_Y_ONLY = 3'd4;
  localparam logic [FMT_W-1:0] FMT_RAW    = 3'd5;

  // Color depth codes; anything above DEPTH_16 counts as 8 bits
  localparam logic [DEPTH_W-1:0] DEPTH_6  = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_8  = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_10 = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_12 = 3'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_14 = 3'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_16 = 3'd5;

  // Link rate codes
  localparam logic [RATE_W-1:0] RATE_1G62 = 2'd0;
  localparam logic [RATE_W-1:0] RATE_2G7  = 2'd1;
  localparam logic [RATE_W-1:0] RATE_5G4  = 2'd2;
  localparam logic [RATE_W-1:0] RATE_8G1  = 2'd3;

  // Lane count codes
  localparam logic [LANE_W-1:0] LANE_X1 = 2'd0;
  localparam logic [LANE_W-1:0] LANE_X2 = 2'd1;
  localparam logic [LANE_W-1:0] LANE_X4 = 2'd2;

  // Override register codes meaning automatic choice
  localparam logic [CFG_DATA_W-1:0] FORCED_RATE_AUTO  = 3'd4;
  localparam logic [LANE_W-1:0]     FORCED_LANES_AUTO = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_LANES = 1'b1;

  // Inclusive bandwidth limits (kbit/s) for each rate/lane choice
  localparam logic [BW_W-1:0] BW_MAX_X1_RBR  = 28'd1620000;
  localparam logic [BW_W-1:0] BW_MAX_X2_RBR  = 28'd3240000;
  localparam logic [BW_W-1:0] BW_MAX_X4_RBR  = 28'd6480000;
  localparam logic [BW_W-1:0] BW_MAX_X4_HBR  = 28'd10800000;
  localparam logic [BW_W-1:0] BW_MAX_X4_HBR2 = 28'd21600000;
  localparam logic [BW_W-1:0] BW_MAX_X4_HBR3 = 28'd32400000;

  // Downspread divisor and its reciprocal, scaled by 2^DIV_SHIFT
  localparam int              DIV_SHIFT  = 32;
  localparam int              RECIP_W    = 25;
  localparam logic [BW_W-1:0] DIV199     = 28'd199;
  localparam logic [RECIP_W-1:0] RECIP_199 = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd199);

  // Bits per pixel: base bits of the format times bits per component over 8
  function automatic logic [BPP_W-1:0] bits_per_pixel(input logic [FMT_W-1:0]   fmt,
                                                      input logic [DEPTH_W-1:0] depth);
    logic [4:0] base;
    logic [4:0] bpc;
    logic [9:0] prod;
    unique case (fmt)
      FMT_RGB:    base = 5'd24;
      FMT_YUV444: base = 5'd24;
      FMT_YUV422: base = 5'd16;
      FMT_YUV420: base = 5'd12;
      FMT_Y_ONLY: base = 5'd8;
      FMT_RAW:    base = 5'd8;
      default:    base = 5'd24;
    endcase
    unique case (depth)
      DEPTH_6:  bpc = 5'd6;
      DEPTH_8:  bpc = 5'd8;
      DEPTH_10: bpc = 5'd10;
      DEPTH_12: bpc = 5'd12;
      DEPTH_14: bpc = 5'd14;
      DEPTH_16: bpc = 5'd16;
      default:  bpc = 5'd8;
    endcase
    prod = 10'(base) * 10'(bpc);
    return prod[8:3];
  endfunction

endpackage

FILE: hdl/dp_link_rate_lane_select_top.sv
// The selector takes one video format word per clock and returns one result
// word per clock while out_ready is high. It is a seven-register pipeline:
// input register, pixel-clock multiply, 8b/10b scaling, reciprocal multiply
// for the downspread share, its correction, the FEC share, and the result
// register holding the rate/lane decision. A stalled output only holds the
// stages behind it until an empty stage is reached, so input keeps flowing
// while bubbles remain. forced_rate (index 0) and forced_lanes (index 1)
// override the automatic choice unless the bandwidth exceeds four lanes at
// 8.1G; write them only while the block is empty.
// ----------------------------------------------------------------------------
// dp_link_rate_lane_select_top: DP link rate and lane count selector
// Computes link bandwidth from pixel clock, color format and depth, and picks
// the lowest link rate, then the fewest lanes, that carry it, unless overridden.
// ----------------------------------------------------------------------------
module dp_link_rate_lane_select_top (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [dlrls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dlrls_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dlrls_pkg::PIX_W-1:0]         pixel_freq_khz,
  input  logic [dlrls_pkg::FMT_W-1:0]         color_format,
  input  logic [dlrls_pkg::DEPTH_W-1:0]       color_depth,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dlrls_pkg::BW_W-1:0]          total_bw,
  output logic [dlrls_pkg::RATE_W-1:0]        rate_code,
  output logic [dlrls_pkg::LANE_W-1:0]        lane_code,
  output logic                                too_high
);

  localparam int NST = 7;

  // Stage control
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // Configuration registers
  logic [dlrls_pkg::CFG_DATA_W-1:0] forced_rate;
  logic [dlrls_pkg::LANE_W-1:0]     forced_lanes;

  // Stage registers
  logic [dlrls_pkg::PIX_W-1:0]   pix0;
  logic [dlrls_pkg::FMT_W-1:0]   fmt0;
  logic [dlrls_pkg::DEPTH_W-1:0] dep0;
  logic [dlrls_pkg::BW_W-1:0]    prod1;
  logic [dlrls_pkg::BW_W-1:0]    coded2;
  logic [dlrls_pkg::BW_W-1:0]    coded3;
  logic [dlrls_pkg::QUOT_W-1:0]  qest3;
  logic [dlrls_pkg::BW_W-1:0]    spread4;
  logic [dlrls_pkg::BW_W-1:0]    bw5;

  // Combinational values
  logic [dlrls_pkg::BPP_W-1:0]   bpp_c;
  logic [dlrls_pkg::BW_W-1:0]    prod_c;
  logic [29:0]                   x5_c;
  logic [dlrls_pkg::BW_W+dlrls_pkg::RECIP_W-1:0] recip_prod_c;
  logic [dlrls_pkg::BW_W-1:0]    qest_x199_c;
  logic [dlrls_pkg::BW_W-1:0]    rem_c;
  logic [dlrls_pkg::QUOT_W-1:0]  quot_c;
  logic [29:0]                   x3_c;
  logic [dlrls_pkg::BW_W-1:0]    bw_c;
  logic [dlrls_pkg::RATE_W-1:0]  rate_c;
  logic [dlrls_pkg::LANE_W-1:0]  lane_c;
  logic                          err_c;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  // Track which stages hold a word
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Write override registers
  always_ff @(posedge clk) begin
    if (rst) begin
      forced_rate  <= dlrls_pkg::FORCED_RATE_AUTO;
      forced_lanes <= dlrls_pkg::FORCED_LANES_AUTO;
    end else if (cfg_we) begin
      if (cfg_index == dlrls_pkg::CFG_FORCED_RATE) begin
        forced_rate <= cfg_data;
      end else begin
        forced_lanes <= cfg_data[dlrls_pkg::LANE_W-1:0];
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix0 <= pixel_freq_khz;
      fmt0 <= color_format;
      dep0 <= color_depth;
    end
  end

  // Multiply pixel clock by bits per pixel
  assign bpp_c  = dlrls_pkg::bits_per_pixel(fmt0, dep0);
  assign prod_c = dlrls_pkg::BW_W'(pix0) * dlrls_pkg::BW_W'(bpp_c);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1 <= prod_c;
    end
  end

  // Apply the 8b/10b factor: times 10 over 8 equals times 5 over 4
  assign x5_c = {prod1, 2'b00} + 30'(prod1);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      coded2 <= x5_c[29:2];
    end
  end

  // Estimate the downspread share by reciprocal multiply
  assign recip_prod_c = (dlrls_pkg::BW_W + dlrls_pkg::RECIP_W)'(coded2)
                      * (dlrls_pkg::BW_W + dlrls_pkg::RECIP_W)'(dlrls_pkg::RECIP_199);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      coded3 <= coded2;
      qest3  <= recip_prod_c[dlrls_pkg::DIV_SHIFT +: dlrls_pkg::QUOT_W];
    end
  end

  // Correct the estimate (at most one short) and add the share
  assign qest_x199_c = dlrls_pkg::BW_W'(qest3) * dlrls_pkg::DIV199;
  assign rem_c       = coded3 - qest_x199_c;
  assign quot_c      = qest3 + dlrls_pkg::QUOT_W'(rem_c >= dlrls_pkg::DIV199);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      spread4 <= coded3 + dlrls_pkg::BW_W'(quot_c);
    end
  end

  // Add the FEC share: times 3 over 256
  assign x3_c = {spread4, 1'b0} + 30'(spread4);
  assign bw_c = spread4 + dlrls_pkg::BW_W'(x3_c[29:8]);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      bw5 <= bw_c;
    end
  end

  // Pick the lowest rate, then fewest lanes; apply overrides unless too high
  always_comb begin
    rate_c = dlrls_pkg::RATE_1G62;
    lane_c = dlrls_pkg::LANE_X1;
    err_c  = 1'b0;
    priority if (bw5 <= dlrls_pkg::BW_MAX_X1_RBR) begin
      rate_c = dlrls_pkg::RATE_1G62;
      lane_c = dlrls_pkg::LANE_X1;
    end else if (bw5 <= dlrls_pkg::BW_MAX_X2_RBR) begin
      rate_c = dlrls_pkg::RATE_1G62;
      lane_c = dlrls_pkg::LANE_X2;
    end else if (bw5 <= dlrls_pkg::BW_MAX_X4_RBR) begin
      rate_c = dlrls_pkg::RATE_1G62;
      lane_c = dlrls_pkg::LANE_X4;
    end else if (bw5 <= dlrls_pkg::BW_MAX_X4_HBR) begin
      rate_c = dlrls_pkg::RATE_2G7;
      lane_c = dlrls_pkg::LANE_X4;
    end else if (bw5 <= dlrls_pkg::BW_MAX_X4_HBR2) begin
      rate_c = dlrls_pkg::RATE_5G4;
      lane_c = dlrls_pkg::LANE_X4;
    end else if (bw5 <= dlrls_pkg::BW_MAX_X4_HBR3) begin
      rate_c = dlrls_pkg::RATE_8G1;
      lane_c = dlrls_pkg::LANE_X4;
    end else begin
      err_c = 1'b1;
    end
    if (!err_c) begin
      if (forced_rate < dlrls_pkg::FORCED_RATE_AUTO) begin
        rate_c = forced_rate[dlrls_pkg::RATE_W-1:0];
      end
      if (forced_lanes < dlrls_pkg::FORCED_LANES_AUTO) begin
        lane_c = forced_lanes;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (en[6]) begin
      total_bw  <= bw5;
      rate_code <= rate_c;
      lane_code <= lane_c;
      too_high  <= err_c;
    end
  end

  // Reciprocal estimate of bw/199 is never more than one short
  a_recip_close: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> rem_c < (dlrls_pkg::DIV199 << 1))
    else $error("downspread quotient estimate off by more than one");

  // Error result carries zero codes and an out-of-range bandwidth
  a_err_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_high |-> rate_code == dlrls_pkg::RATE_1G62
      && lane_code == dlrls_pkg::LANE_X1 && total_bw > dlrls_pkg::BW_MAX_X4_HBR3)
    else $error("too_high result with nonzero codes or in-range bandwidth");

  // Automatic choice uses four lanes before raising the rate
  a_auto_lanes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !too_high && forced_rate >= dlrls_pkg::FORCED_RATE_AUTO
      && forced_lanes == dlrls_pkg::FORCED_LANES_AUTO
      && rate_code != dlrls_pkg::RATE_1G62 |-> lane_code == dlrls_pkg::LANE_X4)
    else $error("automatic rate raised before using four lanes");

  // Automatic lowest rate only when bandwidth fits four lanes at 1.62G
  a_auto_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && !too_high && forced_rate >= dlrls_pkg::FORCED_RATE_AUTO
      && rate_code == dlrls_pkg::RATE_1G62 |-> total_bw <= dlrls_pkg::BW_MAX_X4_RBR)
    else $error("automatic rate too low for bandwidth");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: link rate and lane count selector check
// Drives video format words through the selector under several override
// settings. A directed table covers the field extremes, invalid format and
// depth codes and every bandwidth threshold. Random words follow, many of
// them placed right at a threshold. Every result word is compared field by
// field with an in-bench prediction of the bandwidth and the rate/lane pick.
// ----------------------------------------------------------------------------
module testbench;
  import dlrls_pkg::*;

  localparam int IDLE_PCT           = 15;
  localparam int DRAIN_CYCLES       = 12;   // seven-stage pipe plus margin
  localparam int STALL_LIMIT        = 2000;
  localparam int RANDOM_PER_SETTING = 50;
  localparam int NO_LIMIT           = -1;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Codes the selector folds back onto defaults
  localparam logic [FMT_W-1:0]      FMT_BAD_LO   = 3'd6;
  localparam logic [FMT_W-1:0]      FMT_BAD_HI   = 3'd7;
  localparam logic [DEPTH_W-1:0]    DEPTH_BAD_LO = 3'd6;
  localparam logic [DEPTH_W-1:0]    DEPTH_BAD_HI = 3'd7;
  localparam logic [CFG_DATA_W-1:0] FORCED_RATE_SPARE_LO  = 3'd5;
  localparam logic [CFG_DATA_W-1:0] FORCED_RATE_SPARE_MID = 3'd6;
  localparam logic [CFG_DATA_W-1:0] FORCED_RATE_SPARE_HI  = 3'd7;

  localparam logic [BW_W-1:0] LINK_LIMITS [6] = '{
    BW_MAX_X1_RBR, BW_MAX_X2_RBR, BW_MAX_X4_RBR,
    BW_MAX_X4_HBR, BW_MAX_X4_HBR2, BW_MAX_X4_HBR3
  };

  typedef struct packed {
    logic [BW_W-1:0]   bw;
    logic [RATE_W-1:0] rate;
    logic [LANE_W-1:0] lanes;
    logic              too_high;
  } link_choice_t;

  localparam link_choice_t ZERO_LINK = '{BW_W'(0), RATE_1G62, LANE_X1, 1'b0};

  typedef struct {
    logic [PIX_W-1:0]   pix;
    logic [FMT_W-1:0]   fmt;
    logic [DEPTH_W-1:0] depth;
    int                 limit_sel;  // threshold to sit on, or NO_LIMIT
    bit                 above;      // one pixel clock step past the threshold
    bit                 fixed;      // result typed in below
    link_choice_t       want;
  } format_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] rate;
    logic [LANE_W-1:0]     lanes;
    bit                    calm;
  } override_t;

  format_row_t format_table [25] = '{
    '{PIX_W'(0), FMT_RGB, DEPTH_6, NO_LIMIT, 1'b0, 1'b1, ZERO_LINK},
    '{PIX_W'(0), FMT_RAW, DEPTH_16, NO_LIMIT, 1'b0, 1'b1, ZERO_LINK},
    '{PIX_MAX, FMT_RGB, DEPTH_16, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_MAX, FMT_Y_ONLY, DEPTH_6, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(148500), FMT_YUV444, DEPTH_8, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(148500), FMT_YUV422, DEPTH_10, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(594000), FMT_YUV420, DEPTH_12, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(297000), FMT_RAW, DEPTH_14, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(25175), FMT_Y_ONLY, DEPTH_8, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(148500), FMT_BAD_LO, DEPTH_8, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(148500), FMT_BAD_HI, DEPTH_16, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(74250), FMT_RGB, DEPTH_BAD_LO, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(74250), FMT_YUV444, DEPTH_BAD_HI, NO_LIMIT, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_RGB, DEPTH_8, 0, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_RGB, DEPTH_8, 0, 1'b1, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_YUV422, DEPTH_10, 1, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_YUV422, DEPTH_10, 1, 1'b1, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_YUV444, DEPTH_12, 2, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_YUV444, DEPTH_12, 2, 1'b1, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_RAW, DEPTH_16, 3, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_RAW, DEPTH_16, 3, 1'b1, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_RGB, DEPTH_16, 4, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_RGB, DEPTH_16, 4, 1'b1, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_BAD_HI, DEPTH_16, 5, 1'b0, 1'b0, ZERO_LINK},
    '{PIX_W'(0), FMT_RGB, DEPTH_16, 5, 1'b1, 1'b0, ZERO_LINK}
  };

  // Reset values first, then the extremes and the spare rate codes
  override_t overrides [8] = '{
    '{FORCED_RATE_AUTO, FORCED_LANES_AUTO, 1'b0},
    '{CFG_DATA_W'(RATE_1G62), LANE_X1, 1'b0},
    '{CFG_DATA_W'(RATE_8G1), LANE_X4, 1'b1},
    '{FORCED_RATE_SPARE_HI, FORCED_LANES_AUTO, 1'b0},
    '{CFG_DATA_W'(RATE_2G7), LANE_X2, 1'b0},
    '{CFG_DATA_W'(RATE_5G4), FORCED_LANES_AUTO, 1'b0},
    '{FORCED_RATE_SPARE_LO, LANE_X1, 1'b0},
    '{FORCED_RATE_SPARE_MID, LANE_X4, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FORCED_RATE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_freq_khz = '0;
  logic [FMT_W-1:0]      color_format = FMT_RGB;
  logic [DEPTH_W-1:0]    color_depth = DEPTH_8;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BW_W-1:0]       total_bw;
  logic [RATE_W-1:0]     rate_code;
  logic [LANE_W-1:0]     lane_code;
  logic                  too_high;

  // Override registers as the selector should hold them
  logic [CFG_DATA_W-1:0] forced_rate_q = FORCED_RATE_AUTO;
  logic [LANE_W-1:0]     forced_lanes_q = FORCED_LANES_AUTO;

  link_choice_t pending_links [$];
  bit           calm = 1'b0;
  int           words_sent = 0;
  int           results_seen = 0;
  int           too_high_seen = 0;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;

  dp_link_rate_lane_select_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_freq_khz (pixel_freq_khz),
    .color_format   (color_format),
    .color_depth    (color_depth),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .total_bw       (total_bw),
    .rate_code      (rate_code),
    .lane_code      (lane_code),
    .too_high       (too_high)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Link bandwidth in kbit/s: bpp times pixel clock, 8b/10b, downspread, FEC
  function automatic longint unsigned link_bw(input logic [PIX_W-1:0]   pix,
                                              input logic [FMT_W-1:0]   fmt,
                                              input logic [DEPTH_W-1:0] depth);
    longint unsigned base;
    longint unsigned bpc;
    longint unsigned bw;
    case (fmt)
      FMT_YUV422:          base = 16;
      FMT_YUV420:          base = 12;
      FMT_Y_ONLY, FMT_RAW: base = 8;
      default:             base = 24;
    endcase
    case (depth)
      DEPTH_6:  bpc = 6;
      DEPTH_10: bpc = 10;
      DEPTH_12: bpc = 12;
      DEPTH_14: bpc = 14;
      DEPTH_16: bpc = 16;
      default:  bpc = 8;
    endcase
    bw = pix * ((base * bpc) / 8);
    bw = bw * 10 / 8;
    bw = bw + bw / 199;
    bw = bw + bw * 3 / 256;
    return bw;
  endfunction

  // Expected result word under the current override registers
  function automatic link_choice_t predict_link(input logic [PIX_W-1:0]   pix,
                                                input logic [FMT_W-1:0]   fmt,
                                                input logic [DEPTH_W-1:0] depth);
    longint unsigned bw;
    link_choice_t    r;
    bw = link_bw(pix, fmt, depth);
    r.bw = BW_W'(bw);
    r.too_high = 1'b0;
    if (bw <= BW_MAX_X1_RBR) begin
      r.rate = RATE_1G62; r.lanes = LANE_X1;
    end else if (bw <= BW_MAX_X2_RBR) begin
      r.rate = RATE_1G62; r.lanes = LANE_X2;
    end else if (bw <= BW_MAX_X4_RBR) begin
      r.rate = RATE_1G62; r.lanes = LANE_X4;
    end else if (bw <= BW_MAX_X4_HBR) begin
      r.rate = RATE_2G7; r.lanes = LANE_X4;
    end else if (bw <= BW_MAX_X4_HBR2) begin
      r.rate = RATE_5G4; r.lanes = LANE_X4;
    end else if (bw <= BW_MAX_X4_HBR3) begin
      r.rate = RATE_8G1; r.lanes = LANE_X4;
    end else begin
      r.rate = RATE_1G62; r.lanes = LANE_X1; r.too_high = 1'b1;
    end
    // Overrides apply only when the bandwidth fits at all
    if (!r.too_high) begin
      if (forced_rate_q < FORCED_RATE_AUTO) r.rate = RATE_W'(forced_rate_q);
      if (forced_lanes_q != FORCED_LANES_AUTO) r.lanes = forced_lanes_q;
    end
    return r;
  endfunction

  // Largest pixel clock whose bandwidth stays within a threshold
  function automatic logic [PIX_W-1:0] top_pix_within(input logic [FMT_W-1:0]   fmt,
                                                      input logic [DEPTH_W-1:0] depth,
                                                      input logic [BW_W-1:0]    limit);
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] mid;
    if (link_bw(PIX_MAX, fmt, depth) <= limit) return PIX_MAX;
    lo = '0;
    hi = PIX_MAX;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (link_bw(mid, fmt, depth) <= limit) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
             results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Offer one format word, idling at random first; returns at the next falling edge
  task automatic push_format(input logic [PIX_W-1:0]   pix,
                             input logic [FMT_W-1:0]   fmt,
                             input logic [DEPTH_W-1:0] depth,
                             input bit                 fixed,
                             input link_choice_t       want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    pixel_freq_khz <= pix;
    color_format   <= fmt;
    color_depth    <= depth;
    do @(posedge clk); while (!in_ready);
    pending_links.push_back(fixed ? want : predict_link(pix, fmt, depth));
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every pending result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_links.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result side stalls at random except in calm stretches
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    link_choice_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (too_high === 1'b1) too_high_seen++;
      if (pending_links.size() == 0) begin
        report_mismatch("word with nothing pending, total_bw", total_bw, 0);
      end else begin
        want = pending_links.pop_front();
        if (total_bw !== want.bw) report_mismatch("total_bw", total_bw, want.bw);
        if (rate_code !== want.rate) report_mismatch("rate_code", rate_code, want.rate);
        if (lane_code !== want.lanes) report_mismatch("lane_code", lane_code, want.lanes);
        if (too_high !== want.too_high)
          report_mismatch("too_high", too_high, want.too_high);
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TIMEOUT: no word moved for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    format_row_t        row;
    logic [PIX_W-1:0]   pix;
    logic [FMT_W-1:0]   fmt;
    logic [DEPTH_W-1:0] depth;
    longint             near;
    int                 pick;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (overrides[p]) begin
      drain_results();
      calm = overrides[p].calm;

      // Write both override registers while the pipe is empty
      cfg_we    <= 1'b1;
      cfg_index <= CFG_FORCED_RATE;
      cfg_data  <= overrides[p].rate;
      @(negedge clk);
      cfg_index <= CFG_FORCED_LANES;
      cfg_data  <= CFG_DATA_W'(overrides[p].lanes);
      @(negedge clk);
      cfg_we <= 1'b0;
      forced_rate_q  = overrides[p].rate;
      forced_lanes_q = overrides[p].lanes;

      // Directed table under the reset setting
      if (p == 0) begin
        foreach (format_table[i]) begin
          row = format_table[i];
          pix = row.pix;
          if (row.limit_sel != NO_LIMIT) begin
            pix = top_pix_within(row.fmt, row.depth, LINK_LIMITS[row.limit_sel]);
            if (row.above && pix != PIX_MAX) pix = pix + 1'b1;
          end
          push_format(pix, row.fmt, row.depth, row.fixed, row.want);
        end
      end

      // Random words: full range, small, threshold hugging, top end, video clocks
      repeat (RANDOM_PER_SETTING) begin
        fmt   = FMT_W'($urandom_range(7));
        depth = DEPTH_W'($urandom_range(7));
        pick  = $urandom_range(99);
        if (pick < 35) begin
          pix = PIX_W'($urandom());
        end else if (pick < 50) begin
          pix = PIX_W'($urandom_range(1000));
        end else if (pick < 85) begin
          near = longint'(top_pix_within(fmt, depth, LINK_LIMITS[$urandom_range(5)]))
                 + int'($urandom_range(2)) - 1;
          if (near < 0) near = 0;
          if (near > longint'(PIX_MAX)) near = longint'(PIX_MAX);
          pix = PIX_W'(near);
        end else if (pick < 92) begin
          pix = PIX_MAX - PIX_W'($urandom_range(15));
        end else begin
          pix = PIX_W'($urandom_range(600000, 25000));
        end
        push_format(pix, fmt, depth, 1'b0, ZERO_LINK);
      end
    end

    drain_results();
    $display("Sent %0d format words over %0d override settings, thresholds and spare codes included.",
             words_sent, $size(overrides));
    $display("Checked %0d results, %0d flagged too high, %0d mismatches.",
             results_seen, too_high_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dlrls_pkg.sv
hdl/dp_link_rate_lane_select_top.sv
test/testbench.sv
